[rtl/tfav_pkg.sv]
// Shared constants for the triangle face area and volume block.
package tfav_pkg;

	localparam int AREA_W    = 38;
	localparam int VOL_W     = 53;
	localparam int OUT_DW    = 96;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;

endpackage

[rtl/tfav_isqrt.sv]
// Pipelined truncated integer square root, one root bit per stage.
module tfav_isqrt #(
	parameter int RW = 18
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [2*RW-1:0] n_s    [0:RW];
	logic [RW+1:0]   rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];

	assign n_s[0]    = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic [RW+3:0] cat;
		logic [RW+3:0] trial;
		logic [RW+3:0] diff;
		logic          take;

		assign cat   = {rem_s[j], n_s[j][2*RW-1 -: 2]};
		assign trial = {2'b00, root_s[j], 2'b01};
		assign diff  = cat - trial;
		assign take  = cat >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j+1]    <= {n_s[j][2*RW-3:0], 2'b00};
				rem_s[j+1]  <= take ? diff[RW+1:0] : cat[RW+1:0];
				root_s[j+1] <= {root_s[j][RW-2:0], take};
			end
		end
	end

	assign root = root_s[RW];

endmodule

[rtl/tfav_delay.sv]
// Enabled delay line for words that wait beside a longer path.
module tfav_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

[rtl/triangle_face_area_volume_orient.sv]
// Top level: Heron face area, signed volume about the centre, winding flag.
//
// Usage: one triangle word enters on the s_ channel, one result word
// leaves on the m_ channel for each accepted triangle, in order.
// s_tdata holds the nine corner coordinates, COORD_WIDTH bits each,
// A.x A.y A.z B.x B.y B.z C.x C.y C.z from the lowest bit up.
// m_tdata holds area_times_four (38 bits) then six_volume (53 bits);
// m_tuser holds reverse_winding.
// The centre is written through cfg_we/cfg_idx/cfg_data while idle.
// The path runs through the two bit-per-stage square root pipelines in series.
// Throughput is one triangle per cycle while the output is not stalled.
// The whole pipeline advances together; when m_tready is low with a word
// waiting at the output, every stage holds and s_tready drops, so nothing
// is lost or repeated. Bubbles move on while the output is empty.
// Reset clears the valid bits and sets the centre to zero.
module triangle_face_area_volume_orient #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// corner_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// area_times_four, six_volume, zero fill
	output logic [tfav_pkg::OUT_DW-1:0] m_tdata,
	// reverse_winding
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [tfav_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	import tfav_pkg::*;

	localparam int C    = COORD_WIDTH;
	localparam int D    = C + 1;
	localparam int SQ_W = 2 * C + 4;
	localparam int ER   = C + 2;
	localparam int FW   = ER + 3;
	localparam int AR   = 2 * C + 8;
	localparam int H    = AR / 2;
	localparam int PW   = 2 * AR;
	localparam int VW   = 3 * D + 3;
	localparam int VD   = 1 + ER + AR;
	localparam int LAT  = 7 + ER + AR;

	logic en;
	logic [1:LAT] v_q;

	assign en       = !v_q[LAT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {s_tvalid, v_q[1:LAT-1]};
		end
	end

	// centre registers
	logic signed [C-1:0] cen_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) cen_q[k] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER_X: cen_q[0] <= cfg_data;
				REG_CENTER_Y: cen_q[1] <= cfg_data;
				REG_CENTER_Z: cen_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [D-1:0] crd [9];
	logic signed [D-1:0] cen [3];

	for (genvar i = 0; i < 9; i++) begin : g_crd
		assign crd[i] = {s_tdata[i*C+C-1], s_tdata[i*C +: C]};
	end
	for (genvar k = 0; k < 3; k++) begin : g_cen
		assign cen[k] = {cen_q[k][C-1], cen_q[k]};
	end

	// stage 1: edge vectors A-B, B-C, C-A and corners about the centre
	logic signed [D-1:0] ed_s1  [3][3];
	logic signed [D-1:0] uvw_s1 [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ed_s1[0][k] <= crd[k]     - crd[3 + k];
				ed_s1[1][k] <= crd[3 + k] - crd[6 + k];
				ed_s1[2][k] <= crd[6 + k] - crd[k];
				for (int p = 0; p < 3; p++) begin
					uvw_s1[p][k] <= crd[3*p + k] - cen[k];
				end
			end
		end
	end

	// stage 2: squared edge lengths, cross product partials
	logic signed [2*D-1:0] esq [3][3];
	logic [SQ_W-1:0]       sq_s2 [3];
	logic signed [2*D-1:0] pr   [6];
	logic signed [2*D-1:0] pr_s2 [6];
	logic signed [D-1:0]   u_s2 [3];

	for (genvar e = 0; e < 3; e++) begin : g_esq
		for (genvar k = 0; k < 3; k++) begin : g_k
			assign esq[e][k] = ed_s1[e][k] * ed_s1[e][k];
		end
	end

	assign pr[0] = uvw_s1[1][1] * uvw_s1[2][2];
	assign pr[1] = uvw_s1[1][2] * uvw_s1[2][1];
	assign pr[2] = uvw_s1[1][2] * uvw_s1[2][0];
	assign pr[3] = uvw_s1[1][0] * uvw_s1[2][2];
	assign pr[4] = uvw_s1[1][0] * uvw_s1[2][1];
	assign pr[5] = uvw_s1[1][1] * uvw_s1[2][0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				sq_s2[e] <= SQ_W'(unsigned'(esq[e][0])) + SQ_W'(unsigned'(esq[e][1]))
					+ SQ_W'(unsigned'(esq[e][2]));
			end
			for (int i = 0; i < 6; i++) pr_s2[i] <= pr[i];
			for (int k = 0; k < 3; k++) u_s2[k] <= uvw_s1[0][k];
		end
	end

	// volume: stage 3 cross product, stage 4 dot terms, stage 5 sum
	logic signed [2*D:0]   cr_s3 [3];
	logic signed [D-1:0]   u_s3  [3];
	logic signed [3*D:0]   tm    [3];
	logic signed [3*D:0]   tm_s4 [3];
	logic signed [VW-1:0]  vol_s5;

	for (genvar k = 0; k < 3; k++) begin : g_tm
		assign tm[k] = u_s3[k] * cr_s3[k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				cr_s3[k] <= (2*D+1)'(pr_s2[2*k]) - (2*D+1)'(pr_s2[2*k+1]);
				u_s3[k]  <= u_s2[k];
				tm_s4[k] <= tm[k];
			end
			vol_s5 <= VW'(tm_s4[0]) + VW'(tm_s4[1]) + VW'(tm_s4[2]);
		end
	end

	logic [VW-1:0] vol_dl;

	tfav_delay #(.W(VW), .DEPTH(VD)) u_vol_dly (
		.clk (clk),
		.en  (en),
		.d   (vol_s5),
		.q   (vol_dl)
	);

	// edge lengths
	logic [ER-1:0] eg [3];

	for (genvar e = 0; e < 3; e++) begin : g_edge
		tfav_isqrt #(.RW(ER)) u_edge (
			.clk  (clk),
			.en   (en),
			.rad  (sq_s2[e]),
			.root (eg[e])
		);
	end

	// Heron factors
	logic signed [FW-1:0] ea, eb, ec;
	logic signed [FW-1:0] f_sf [4];
	logic                 neg_sf;
	logic signed [FW-1:0] f1, f2, f3, f4;

	assign ea = FW'(eg[0]);
	assign eb = FW'(eg[1]);
	assign ec = FW'(eg[2]);
	assign f1 = ea + eb + ec;
	assign f2 = eb + ec - ea;
	assign f3 = ea + ec - eb;
	assign f4 = ea + eb - ec;

	logic [AR-1:0]   x_sm, y_sm;
	logic [AR+H-1:0] plo_sn, phi_sn;
	logic [PW-1:0]   p_sp;
	logic [2*FW-1:0] x_full, y_full;

	assign x_full = unsigned'(f_sf[0]) * unsigned'(f_sf[1]);
	assign y_full = unsigned'(f_sf[2]) * unsigned'(f_sf[3]);

	always_ff @(posedge clk) begin
		if (en) begin
			f_sf[0] <= f1;
			f_sf[1] <= f2;
			f_sf[2] <= f3;
			f_sf[3] <= f4;
			neg_sf  <= f2[FW-1] || f3[FW-1] || f4[FW-1];
			x_sm    <= neg_sf ? '0 : x_full[AR-1:0];
			y_sm    <= neg_sf ? '0 : y_full[AR-1:0];
			plo_sn  <= x_sm * y_sm[H-1:0];
			phi_sn  <= x_sm * y_sm[AR-1:H];
			p_sp    <= PW'(plo_sn) + (PW'(phi_sn) << H);
		end
	end

	logic [AR-1:0] root;

	tfav_isqrt #(.RW(AR)) u_area (
		.clk  (clk),
		.en   (en),
		.rad  (p_sp),
		.root (root)
	);

	// output register with saturation
	logic [AREA_W-1:0] area_sat;
	logic [VOL_W-1:0]  vol_sat;
	logic [AREA_W-1:0] area_q;
	logic [VOL_W-1:0]  vol_q;
	logic              rev_q;

	if (AR > AREA_W) begin : g_area_sat
		assign area_sat = (|root[AR-1:AREA_W]) ? '1 : root[AREA_W-1:0];
	end else begin : g_area_ext
		assign area_sat = AREA_W'(root);
	end

	if (VW > VOL_W) begin : g_vol_sat
		logic ovf;
		assign ovf = !((&vol_dl[VW-1:VOL_W-1]) || !(|vol_dl[VW-1:VOL_W-1]));
		assign vol_sat = !ovf ? vol_dl[VOL_W-1:0]
			: vol_dl[VW-1] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
	end else begin : g_vol_ext
		assign vol_sat = {{(VOL_W-VW){vol_dl[VW-1]}}, vol_dl};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_q <= area_sat;
			vol_q  <= vol_sat;
			rev_q  <= vol_dl[VW-1];
		end
	end

	assign m_tdata = {{(OUT_DW-AREA_W-VOL_W){1'b0}}, vol_q, area_q};
	assign m_tuser = rev_q;

endmodule

[dv/tb_triangle_face_area_volume_orient.sv]
// Testbench for the triangle face area, signed volume and winding block.
module tb_triangle_face_area_volume_orient;
	import tfav_pkg::*;

	localparam int CW = 16;
	localparam int IN_DW = ((9 * CW + 7) / 8) * 8;
	localparam int LATENCY = 65;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [AREA_W-1:0] area4;
		logic [VOL_W-1:0] vol6;
		logic flip;
	} face_meas_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CW-1:0] cfg_data;

	logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
	face_meas_t expected_meas[$];
	int err_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off;

	triangle_face_area_volume_orient #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// truncated square root of a value up to 128 bits
	function automatic logic [63:0] isqrt128(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] edge_length(input longint dx, input longint dy,
			input longint dz);
		return isqrt128(128'(dx * dx + dy * dy + dz * dz));
	endfunction

	function automatic face_meas_t measure_face(input logic [IN_DW-1:0] w);
		longint p[9];
		longint ea, eb, ec, f1, f2, f3, f4;
		longint ux, uy, uz, vx, vy, vz, wx, wy, wz, vol, lim;
		logic [127:0] prod;
		logic [63:0] area;
		face_meas_t r;
		for (int i = 0; i < 9; i++)
			p[i] = longint'($signed(w[i*CW +: CW]));
		ea = longint'(edge_length(p[0] - p[3], p[1] - p[4], p[2] - p[5]));
		eb = longint'(edge_length(p[3] - p[6], p[4] - p[7], p[5] - p[8]));
		ec = longint'(edge_length(p[6] - p[0], p[7] - p[1], p[8] - p[2]));
		f1 = ea + eb + ec;
		f2 = -ea + eb + ec;
		f3 = ea - eb + ec;
		f4 = ea + eb - ec;
		// truncated edges can make a degenerate triangle's factor negative
		if (f2 < 0 || f3 < 0 || f4 < 0) begin
			area = '0;
		end else begin
			prod = 128'(f1 * f2) * 128'(f3 * f4);
			area = isqrt128(prod);
			if (area > 64'((64'd1 << AREA_W) - 1))
				area = (64'd1 << AREA_W) - 1;
		end
		ux = p[0] - ctr_x; uy = p[1] - ctr_y; uz = p[2] - ctr_z;
		vx = p[3] - ctr_x; vy = p[4] - ctr_y; vz = p[5] - ctr_z;
		wx = p[6] - ctr_x; wy = p[7] - ctr_y; wz = p[8] - ctr_z;
		vol = ux * (vy * wz - vz * wy) + uy * (vz * wx - vx * wz) + uz * (vx * wy - vy * wx);
		r.flip = vol < 0;
		lim = longint'(64'd1 << (VOL_W - 1));
		if (vol > lim - 1)
			vol = lim - 1;
		if (vol < -lim)
			vol = -lim;
		r.area4 = area[AREA_W-1:0];
		r.vol6 = vol[VOL_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		face_meas_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_meas.size() == 0) begin
				report_mismatch("unexpected word", 64'(m_tdata), 64'd0);
			end else begin
				e = expected_meas.pop_front();
				if (m_tdata[AREA_W-1:0] !== e.area4)
					report_mismatch("area_times_four", 64'(m_tdata[AREA_W-1:0]), 64'(e.area4));
				if (m_tdata[AREA_W +: VOL_W] !== e.vol6)
					report_mismatch("six_volume", 64'(m_tdata[AREA_W +: VOL_W]), 64'(e.vol6));
				if (m_tuser !== e.flip)
					report_mismatch("reverse_winding", 64'(m_tuser), 64'(e.flip));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// leaves tvalid high on return; the next word or drain() drops it
	task automatic send_face(input logic [IN_DW-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_meas = {expected_meas, measure_face(w)};
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_meas.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(negedge clk);
		case (idx)
			REG_CENTER_X: ctr_x = v;
			REG_CENTER_Y: ctr_y = v;
			REG_CENTER_Z: ctr_z = v;
			default: ;
		endcase
	endtask

	task automatic set_center(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [IN_DW-1:0] pack_face(input logic [CW-1:0] c[9]);
		logic [IN_DW-1:0] w;
		w = '0;
		for (int i = 0; i < 9; i++)
			w[i*CW +: CW] = c[i];
		return w;
	endfunction

	function automatic logic [CW-1:0] rand_coord;
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return CW'($urandom_range(15)) - 16'd8;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [IN_DW-1:0] rand_face;
		logic [CW-1:0] c[9];
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 9; i++)
			c[i] = rand_coord();
		if (kind == 0) begin
			// collinear corners: degenerate triangle
			for (int i = 0; i < 3; i++)
				c[6+i] = c[3+i] + (c[3+i] - c[i]);
		end else if (kind == 1) begin
			for (int i = 0; i < 3; i++)
				c[3+i] = c[i];
		end else if (kind < 5) begin
			// small triangle near a random point
			for (int i = 3; i < 9; i++)
				c[i] = c[i%3] + CW'($urandom_range(200)) - 16'd100;
		end
		return pack_face(c);
	endfunction

	task automatic test_extremes;
		logic [CW-1:0] c[9];
		logic [CW-1:0] vals[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < 4; k++) begin
			foreach (c[i]) c[i] = vals[k];
			send_face(pack_face(c));
		end
		// largest spread and both windings
		c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000};
		send_face(pack_face(c));
		c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h8000};
		send_face(pack_face(c));
		c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h7fff, 16'h8000};
		send_face(pack_face(c));
		// degenerate: corners on a line, truncated edges 1,1,2
		c = '{0, 0, 0, 1, 1, 0, 2, 2, 0};
		send_face(pack_face(c));
		c = '{0, 0, 0, 3, 0, 0, 0, 4, 0};
		send_face(pack_face(c));
		c = '{0, 0, 0, 0, 4, 0, 3, 0, 0};
		send_face(pack_face(c));
		for (int k = 0; k < 8; k++)
			send_face(rand_face());
		drain();
	endtask

	task automatic test_random(input int n, input int sp, input int rp);
		send_idle_pct = sp;
		recv_stall_pct = rp;
		for (int k = 0; k < n; k++)
			send_face(rand_face());
		send_idle_pct = 0;
		drain();
	endtask

	task automatic test_backpressure;
		recv_stall_pct = 0;
		send_idle_pct = 0;
		@(negedge clk);
		hold_off <= 300;
		for (int k = 0; k < 150; k++)
			send_face(rand_face());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		ctr_x = '0;
		ctr_y = '0;
		ctr_z = '0;
		err_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		set_center(16'h7fff, 16'h8000, 16'h0001);
		test_extremes();
		set_center(16'h8000, 16'h7fff, 16'h8000);
		test_random(400, 0, 0);
		set_center(CW'($urandom), CW'($urandom), CW'($urandom));
		test_random(400, 59, 0);
		set_center(16'h0000, 16'h0000, 16'h0000);
		test_random(400, 0, 59);
		set_center(CW'($urandom), CW'($urandom), CW'($urandom));
		test_random(400, 12, 12);
		test_backpressure();
		set_center(16'h7fff, 16'h7fff, 16'h7fff);
		test_random(100, 30, 30);

		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
